// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL, empty when synthesised.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gzhp_pkg.sv =====
// Constants and codes for the gzip member header parser.
package gzhp_pkg;

  localparam logic [7:0] MAGIC_ID1   = 8'h1f;
  localparam logic [7:0] MAGIC_ID2   = 8'h8b;
  localparam logic [7:0] CM_DEFLATE  = 8'd8;

  localparam int unsigned FIXED_LEN  = 10;
  localparam int unsigned CNT_W      = 16;

  // Positions in the fixed header that are checked.
  localparam logic [CNT_W-1:0] POS_ID1  = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_ID2  = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_CM   = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_FLG  = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(FIXED_LEN - 1);

  // FLG bits kept in the low five bits.
  localparam int unsigned FLG_HCRC    = 1;
  localparam int unsigned FLG_EXTRA   = 2;
  localparam int unsigned FLG_NAME    = 3;
  localparam int unsigned FLG_COMMENT = 4;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_FIXED   = 3'd0;
  localparam kind_t KIND_EXTRA   = 3'd1;
  localparam kind_t KIND_NAME    = 3'd2;
  localparam kind_t KIND_COMMENT = 3'd3;
  localparam kind_t KIND_HCRC    = 3'd4;
  localparam kind_t KIND_PAYLOAD = 3'd5;

endpackage

// ===== rtl/core/gzip_header_parser_unit.sv =====
// gzip member header parser: classifies each stream byte, flags bad headers.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | in        | in_valid/in_stall  | data_byte
//  out     | out       | out_valid/out_stall| out_byte, kind, header_end, error
//
// One byte per cycle while in_stall is low; each result is registered in main
// entry, or in skid while main is held. A two-entry buffer (main plus skid) lets
// a byte be taken while a result waits; in_stall rises only when both are full.
// Synchronous reset clears the parse state and both output entries.
`include "assert_macros.svh"

module gzip_header_parser_unit
  import gzhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output kind_t      kind,
  output logic       header_end,
  output logic       error
);

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_XLEN    = 3'd1,
    PH_XDATA   = 3'd2,
    PH_NAME    = 3'd3,
    PH_CMT     = 3'd4,
    PH_HCRC    = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       hdr_end;
    logic       err;
  } result_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [4:0]       flag_bits, flag_bits_next;
  logic [7:0]       extra_low, extra_low_next;
  logic             error_seen, error_seen_next;

  result_t res;
  result_t main_q, skid_q;
  logic    main_valid, skid_valid;
  logic    accept, pop;
  logic    bad;
  logic [CNT_W-1:0] xlen;

  // First enabled optional part at or after 'from'.
  function automatic phase_t next_part(input logic [4:0] flg, input phase_t from);
    phase_t p;
    if (from <= PH_XLEN && flg[FLG_EXTRA]) begin
      p = PH_XLEN;
    end else if (from <= PH_NAME && flg[FLG_NAME]) begin
      p = PH_NAME;
    end else if (from <= PH_CMT && flg[FLG_COMMENT]) begin
      p = PH_CMT;
    end else if (from <= PH_HCRC && flg[FLG_HCRC]) begin
      p = PH_HCRC;
    end else begin
      p = PH_PAYLOAD;
    end
    return p;
  endfunction

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign pop      = main_valid && !out_stall;
  assign xlen     = {data_byte, extra_low};

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    flag_bits_next  = flag_bits;
    extra_low_next  = extra_low;
    error_seen_next = error_seen;
    bad             = 1'b0;
    res.data        = data_byte;
    res.kind        = KIND_PAYLOAD;
    res.hdr_end     = 1'b0;
    if (error_seen) begin
      res.kind = KIND_FIXED;
    end else begin
      unique case (phase)
        PH_FIXED: begin
          res.kind = KIND_FIXED;
          bad = (byte_count == POS_ID1 && data_byte != MAGIC_ID1) ||
                (byte_count == POS_ID2 && data_byte != MAGIC_ID2) ||
                (byte_count == POS_CM  && data_byte != CM_DEFLATE) ||
                (byte_count == POS_FLG && (|data_byte[7:5]));
          if (byte_count == POS_FLG) begin
            flag_bits_next = data_byte[4:0];
          end
          if (bad) begin
            error_seen_next = 1'b1;
          end else if (byte_count >= POS_LAST) begin
            phase_next      = next_part(flag_bits_next, PH_XLEN);
            byte_count_next = '0;
            res.hdr_end     = (phase_next == PH_PAYLOAD);
          end else begin
            byte_count_next = byte_count + CNT_W'(1);
          end
        end
        PH_XLEN: begin
          res.kind = KIND_EXTRA;
          if (byte_count == '0) begin
            extra_low_next  = data_byte;
            byte_count_next = CNT_W'(1);
          end else if (xlen == '0) begin
            phase_next      = next_part(flag_bits, PH_NAME);
            byte_count_next = '0;
            res.hdr_end     = (phase_next == PH_PAYLOAD);
          end else begin
            phase_next      = PH_XDATA;
            byte_count_next = xlen;
          end
        end
        PH_XDATA: begin
          res.kind = KIND_EXTRA;
          if (byte_count <= CNT_W'(1)) begin
            phase_next      = next_part(flag_bits, PH_NAME);
            byte_count_next = '0;
            res.hdr_end     = (phase_next == PH_PAYLOAD);
          end else begin
            byte_count_next = byte_count - CNT_W'(1);
          end
        end
        PH_NAME: begin
          res.kind = KIND_NAME;
          if (data_byte == 8'd0) begin
            phase_next      = next_part(flag_bits, PH_CMT);
            byte_count_next = '0;
            res.hdr_end     = (phase_next == PH_PAYLOAD);
          end
        end
        PH_CMT: begin
          res.kind = KIND_COMMENT;
          if (data_byte == 8'd0) begin
            phase_next      = next_part(flag_bits, PH_HCRC);
            byte_count_next = '0;
            res.hdr_end     = (phase_next == PH_PAYLOAD);
          end
        end
        PH_HCRC: begin
          res.kind = KIND_HCRC;
          if (byte_count == '0) begin
            byte_count_next = CNT_W'(1);
          end else begin
            phase_next      = PH_PAYLOAD;
            byte_count_next = '0;
            res.hdr_end     = 1'b1;
          end
        end
        PH_PAYLOAD: res.kind = KIND_PAYLOAD;
        default:    res.kind = KIND_PAYLOAD;
      endcase
    end
    res.err = error_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIXED;
      byte_count <= '0;
      flag_bits  <= '0;
      extra_low  <= '0;
      error_seen <= 1'b0;
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
      main_q     <= '0;
      skid_q     <= '0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
        flag_bits  <= flag_bits_next;
        extra_low  <= extra_low_next;
        error_seen <= error_seen_next;
      end
      // Output buffer: skid entry only fills when main is held by out_stall.
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
          main_q     <= skid_q;
        end
      end else if (accept) begin
        if (main_valid && !pop) begin
          skid_valid <= 1'b1;
          skid_q     <= res;
        end else begin
          main_valid <= 1'b1;
          main_q     <= res;
        end
      end else if (pop) begin
        main_valid <= 1'b0;
      end
    end
  end

  assign out_valid  = main_valid;
  assign out_byte   = main_q.data;
  assign kind       = main_q.kind;
  assign header_end = main_q.hdr_end;
  assign error      = main_q.err;

  `ASSERT_HOLDS(a_skid_needs_main, clk, rst, !skid_valid || main_valid, "skid full, main empty")
  `ASSERT_NEXT(a_error_sticky, clk, rst, error_seen, error_seen, "error flag cleared")
  `ASSERT_NEXT(a_payload_final, clk, rst, phase == PH_PAYLOAD, phase == PH_PAYLOAD, "left payload")
  `ASSERT_HOLDS(a_end_not_err, clk, rst, !(main_valid && main_q.hdr_end && main_q.err), "bad end")

endmodule
